// File: src/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by every module of the block except lpht_ram.
package lpht_pkg;

    // Field widths
    localparam int KEY_W      = 31;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_IDX_W = 10;

    // Default slot count (a prime keeps the probe chains spread)
    localparam int SLOTS_DEFAULT = 31;

    // Key bits folded into the home remainder per cycle
    localparam int HOME_STEP_BITS = 4;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((KEY_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STATUS_W + VALUE_W + SLOT_IDX_W + 7) / 8) * 8;

    // Operation selected by tuser
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage

// File: src/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 31
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: src/lpht_home.sv
// Home slot unit: key modulo SLOTS, HOME_STEP_BITS key bits per cycle, MSB first.
// Depends on lpht_pkg.
module lpht_home
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [KEY_W-1:0]          key,
    output logic                      done,
    output logic [$clog2(SLOTS)-1:0]  home
);

    localparam int IW    = $clog2(SLOTS);
    localparam int PAD_W = ((KEY_W + HOME_STEP_BITS - 1) / HOME_STEP_BITS) * HOME_STEP_BITS;
    localparam int STEPS = PAD_W / HOME_STEP_BITS;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PAD_W-1:0] shift_reg, shift_next;
    logic [IW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // Fold HOME_STEP_BITS bits: r = (2r + b) mod SLOTS, one compare-subtract each
    function automatic logic [IW-1:0] fold(input logic [IW-1:0] r_in,
                                           input logic [HOME_STEP_BITS-1:0] bits);
        logic [IW:0] r;
        r = {1'b0, r_in};
        for (int b = HOME_STEP_BITS - 1; b >= 0; b--)
        begin
            r = {r[IW-1:0], bits[b]};
            if (r >= (IW+1)'(SLOTS))
            begin
                r = r - (IW+1)'(SLOTS);
            end
        end
        return r[IW-1:0];
    endfunction

    // Next-state logic
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = PAD_W'(key);
            rem_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fold(rem_reg, shift_reg[PAD_W-1 -: HOME_STEP_BITS]);
            shift_next = shift_reg << HOME_STEP_BITS;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

// File: src/linear_probe_hash_table.sv
// Linear probing hash table: controller, home slot unit and slot RAM.
// Depends on lpht_pkg, lpht_ram and lpht_home.
// Sequence: once a transfer is accepted, lpht_home computes the home slot,
//   the first RAM read is issued at the home slot, then one probe per cycle
//   for P probes (1..SLOTS), then the output register is loaded.
// One operation at a time; the next transfer is accepted once the result
//   is in the output register.
// Reset: a clearing pass over all SLOTS slots marks every slot free; no
//   transfer is accepted until it ends.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[30:0], value[62:31], zero pad
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[2:0], found_value[34:3],
                                           // slot_index[44:35], zero pad
);

    localparam int IW = $clog2(SLOTS);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        HOME,
        CHECK,
        RESULT
    } state_t;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          clr_reg, clr_next;
    op_t                    kind_reg, kind_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    status_t                res_status_reg, res_status_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    logic [SLOT_IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                   s_xfer;
    logic                   home_done;
    logic [IW-1:0]          home;
    logic [IW-1:0]          idx_inc;
    logic                   hit;
    logic                   last_probe;
    slot_t                  rd_slot;
    slot_t                  wr_slot;
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [IW-1:0]          ram_raddr;
    logic [$bits(slot_t)-1:0] ram_rdata;

    assign s_tready = (state_reg == IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // Home slot of the incoming key
    lpht_home #(
        .SLOTS (SLOTS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_xfer),
        .key   (s_tdata[KEY_W-1:0]),
        .done  (home_done),
        .home  (home)
    );

    // Slot storage; a probe ends at its write, so reads never overlap it
    lpht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_slot),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Probe compare
    assign rd_slot    = slot_t'(ram_rdata);
    assign idx_inc    = (idx_reg == IW'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign hit        = rd_slot.used && (rd_slot.key == key_reg);
    assign last_probe = (cnt_reg == IW'(SLOTS - 1));
    assign ram_raddr  = (state_reg == HOME) ? home : idx_inc;

    // RAM write: clearing pass, or insert into the first free slot
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        wr_slot   = '{used: 1'b1, key: key_reg, value: value_reg};
        if (state_reg == CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            wr_slot   = '0;
        end
        else if (state_reg == CHECK && kind_reg == OP_INSERT && !rd_slot.used)
        begin
            ram_we = 1'b1;
        end
    end

    // Controller next state
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_idx_next    = res_idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(SLOTS - 1))
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (s_xfer)
                begin
                    kind_next  = op_t'(s_tuser);
                    key_next   = s_tdata[KEY_W-1:0];
                    value_next = s_tdata[KEY_W +: VALUE_W];
                    state_next = HOME;
                end
            end
            HOME:
            begin
                // first read goes out at the home slot this cycle
                if (home_done)
                begin
                    idx_next   = home;
                    cnt_next   = '0;
                    state_next = CHECK;
                end
            end
            CHECK:
            begin
                res_value_next = '0;
                res_idx_next   = '0;
                if (kind_reg == OP_INSERT)
                begin
                    priority if (hit)
                    begin
                        res_status_next = ST_DUPLICATE;
                        res_idx_next    = SLOT_IDX_W'(idx_reg);
                        state_next      = RESULT;
                    end
                    else if (!rd_slot.used)
                    begin
                        res_status_next = ST_INSERTED;
                        res_idx_next    = SLOT_IDX_W'(idx_reg);
                        state_next      = RESULT;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = RESULT;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    priority if (hit)
                    begin
                        res_status_next = ST_FOUND;
                        res_value_next  = rd_slot.value;
                        res_idx_next    = SLOT_IDX_W'(idx_reg);
                        state_next      = RESULT;
                    end
                    else if (!rd_slot.used || last_probe)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = RESULT;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            RESULT:
            begin
                // hand off once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({res_idx_reg, res_value_reg, res_status_reg});
                    state_next    = IDLE;
                end
            end
            default:
            begin
                state_next = CLEAR;
            end
        endcase
    end

    // Controller state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR;
            clr_reg        <= '0;
            kind_reg       <= OP_INSERT;
            key_reg        <= '0;
            value_reg      <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            res_status_reg <= ST_NOT_FOUND;
            res_value_reg  <= '0;
            res_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            kind_reg       <= kind_next;
            key_reg        <= key_next;
            value_reg      <= value_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            res_idx_reg    <= res_idx_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: verif/lpht_checker.sv
// Scoreboard for the linear probing hash table: watches both stream channels,
// keeps its own copy of the slot table and checks every result transfer.
// Depends on lpht_pkg for field widths and the operation and status codes.
module lpht_checker
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[30:0], value[62:31], zero pad
    input  logic                s_tuser,   // kind
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // status[2:0], found_value[34:3],
                                           // slot_index[44:35], zero pad
    output int                  fail_count,
    output int                  results_due,
    output logic [4:0]          statuses_seen
);

    typedef struct {
        status_t                status;
        logic [VALUE_W-1:0]     found_value;
        logic [SLOT_IDX_W-1:0]  slot_index;
    } lookup_result_t;

    // Shadow table
    logic [KEY_W-1:0]   shadow_key [SLOTS];
    logic [VALUE_W-1:0] shadow_val [SLOTS];
    bit                 shadow_used [SLOTS];

    lookup_result_t pending_results [$];
    lookup_result_t want;
    logic [STATUS_W-1:0]   got_status;
    logic [VALUE_W-1:0]    got_value;
    logic [SLOT_IDX_W-1:0] got_slot;
    int                    error_tally;
    logic [4:0]            seen_mask;
    int                    s;

    assign fail_count    = error_tally;
    assign statuses_seen = seen_mask;

    // Apply one operation to the shadow table and return the result it gives
    function automatic lookup_result_t probe_table(op_t op, logic [KEY_W-1:0] key,
                                                   logic [VALUE_W-1:0] value);
        lookup_result_t res;
        int home;
        int idx;
        int n;
        bit hit;
        bit placed;
        res.status      = ST_NOT_FOUND;
        res.found_value = '0;
        res.slot_index  = '0;
        home = int'(key % SLOTS);
        hit = 1'b0;
        placed = 1'b0;
        if (op == OP_INSERT)
        begin
            // duplicate check covers every slot before any free one is taken
            idx = home;
            for (n = 0; n < SLOTS; n++)
            begin
                if (shadow_used[idx] && shadow_key[idx] == key)
                begin
                    hit = 1'b1;
                    break;
                end
                idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
            end
            if (hit)
            begin
                res.status     = ST_DUPLICATE;
                res.slot_index = SLOT_IDX_W'(idx);
            end
            else
            begin
                idx = home;
                for (n = 0; n < SLOTS; n++)
                begin
                    if (!shadow_used[idx])
                    begin
                        shadow_key[idx]  = key;
                        shadow_val[idx]  = value;
                        shadow_used[idx] = 1'b1;
                        placed = 1'b1;
                        break;
                    end
                    idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
                end
                if (placed)
                begin
                    res.status     = ST_INSERTED;
                    res.slot_index = SLOT_IDX_W'(idx);
                end
                else
                    res.status = ST_FULL;
            end
        end
        else
        begin
            // search stops at a free slot, the key, or after one full lap
            idx = home;
            for (n = 0; n < SLOTS; n++)
            begin
                if (!shadow_used[idx])
                    break;
                if (shadow_key[idx] == key)
                begin
                    res.status      = ST_FOUND;
                    res.found_value = shadow_val[idx];
                    res.slot_index  = SLOT_IDX_W'(idx);
                    break;
                end
                idx = (idx + 1 >= SLOTS) ? 0 : idx + 1;
            end
        end
        return res;
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (s = 0; s < SLOTS; s++)
                shadow_used[s] = 1'b0;
            pending_results.delete();
            error_tally = 0;
            seen_mask   = '0;
            results_due <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(probe_table(op_t'(s_tuser),
                                                      s_tdata[KEY_W-1:0],
                                                      s_tdata[KEY_W +: VALUE_W]));
            if (m_tvalid && m_tready)
            begin
                got_status = m_tdata[STATUS_W-1:0];
                got_value  = m_tdata[STATUS_W +: VALUE_W];
                got_slot   = m_tdata[STATUS_W+VALUE_W +: SLOT_IDX_W];
                if (pending_results.size() == 0)
                begin
                    error_tally++;
                    $display("%0t: ERROR unexpected result: status %0d value %h slot %0d",
                             $time, got_status, got_value, got_slot);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got_status != want.status || got_value != want.found_value ||
                        got_slot != want.slot_index)
                    begin
                        error_tally++;
                        $write("%0t: ERROR result mismatch: expected status %0d value %h",
                               $time, want.status, want.found_value);
                        $display(" slot %0d, actual status %0d value %h slot %0d",
                                 want.slot_index, got_status, got_value, got_slot);
                    end
                    else
                        seen_mask[want.status] = 1'b1;
                end
            end
            results_due <= pending_results.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Top of the hash table testbench: clock, reset, stream stimulus and verdict.
// Depends on lpht_pkg, linear_probe_hash_table and lpht_checker.
module tb_top;
    import lpht_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int RANDOM_OPS   = 1935;
    localparam int FILL_FROM    = 1400;   // from here every insert uses a fresh key
    localparam int STALL_LIMIT  = 2000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES = 12 + SLOTS + 8;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int         fail_count;
    int         results_due;
    logic [4:0] statuses_seen;

    logic [KEY_W-1:0] sent_keys [$];
    int  insert_ops;
    int  search_ops;
    bit  no_gap_mode;
    int  wd_count;

    linear_probe_hash_table #(.SLOTS(SLOTS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lpht_checker #(.SLOTS(SLOTS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .results_due   (results_due),
        .statuses_seen (statuses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Gap before an input transfer: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_gap_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Key not drawn from the sent list; some land on crowded home slots
    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom);
            1: return KEY_W'($urandom_range(0, 255));
            2: return KEY_W'(SLOTS * $urandom_range(0, 5000) + $urandom_range(0, 3));
            default: return 31'h7FFF_FFFF - KEY_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        if (sent_keys.size() == 0)
            return fresh_key();
        return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    endfunction

    // One input transfer, preceded by a random idle gap
    task automatic send_op(input op_t op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, value, key};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_INSERT) begin
            insert_ops++;
            sent_keys.push_back(key);
        end
        else
            search_ops++;
    endtask

    // Output side: ready runs broken by stalls, with some stall-free stretches
    initial
    begin
        int on_len;
        int off_len;
        int r;
        m_tready = 1'b0;
        @(posedge clk);
        forever begin
            on_len = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 12);
            r = $urandom_range(0, 99);
            if (r < 70)
                off_len = $urandom_range(1, 2);
            else if (r < 95)
                off_len = $urandom_range(3, 8);
            else
                off_len = $urandom_range(20, 60);
            m_tready <= 1'b1;
            repeat (on_len) @(posedge clk);
            m_tready <= 1'b0;
            repeat (off_len) @(posedge clk);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long
    initial
    begin
        wd_count = 0;
        while (wd_count < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                wd_count = 0;
            else
                wd_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        logic [KEY_W-1:0] key;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_INSERT;
        rst_n       = 1'b0;
        insert_ops  = 0;
        search_ops  = 0;
        no_gap_mode = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, duplicates, wrapping probe chains
        send_op(OP_SEARCH, 31'd0, 32'h0000_0000);
        send_op(OP_INSERT, 31'd0, 32'h8000_0000);
        send_op(OP_INSERT, 31'd0, 32'h0000_0005);
        send_op(OP_SEARCH, 31'd0, 32'h0000_0000);
        send_op(OP_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(OP_SEARCH, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 31'd31, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 31'd30, 32'h0000_0001);
        send_op(OP_INSERT, 31'd61, 32'h5555_5555);
        send_op(OP_SEARCH, 31'd61, 32'h0000_0000);
        send_op(OP_SEARCH, 31'd92, 32'h0000_0000);
        send_op(OP_SEARCH, 31'd31, 32'h0000_0000);
        send_op(OP_INSERT, 31'd61, 32'h1234_5678);
        send_op(OP_INSERT, 31'd62, 32'hAAAA_AAAA);
        send_op(OP_SEARCH, 31'd30, 32'hDEAD_BEEF);
        send_op(OP_SEARCH, 31'h7FFF_FFFE, 32'h0000_0000);

        // Random: the table fills slowly, then stays full for the tail
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 150 == 0)
                no_gap_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) begin
                key = ($urandom_range(0, 9) < 6) ? known_key() : fresh_key();
                send_op(OP_SEARCH, key, $urandom);
            end
            else begin
                if (n >= FILL_FROM || $urandom_range(0, 23) == 0)
                    key = fresh_key();
                else
                    key = known_key();
                send_op(OP_INSERT, key, $urandom);
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d inserts and %0d searches through empty, partial and full table states",
                 insert_ops, search_ops);
        $display("Status codes matched (bit per code, not found down to inserted): %b",
                 statuses_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
